// File: hdl/pals_pkg.sv
// ============================================================================
// pals_pkg : shared types and constants for the loop sampler
// Fixed field widths, configuration register indexes, reset values and the
// control bundle that travels down the pipeline with each beat.
// ============================================================================
package pals_pkg;

    // fixed field widths
    localparam int IO_W       = 24;   // in_sample / out_sample
    localparam int PHASE_W    = 32;   // 0.32 loop phase
    localparam int FC_W       = 17;   // loop length and record index
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LOOP_FRAMES   = 2'd0,
        CFG_PHASE_STEP    = 2'd1,
        CFG_RECORD_ENABLE = 2'd2,
        CFG_BUFFER_VALID  = 2'd3
    } cfg_reg_t;

    // register reset values
    localparam logic [FC_W-1:0]    LOOP_FRAMES_RST   = 17'd44100;
    localparam logic [PHASE_W-1:0] PHASE_STEP_RST    = 32'd97391;
    localparam logic               RECORD_ENABLE_RST = 1'b0;
    localparam logic               BUFFER_VALID_RST  = 1'b1;

    // per-beat control carried through the stages
    typedef struct packed {
        logic vld;      // stage holds a beat
        logic active;   // buffer was valid when the beat was taken
        logic rec;      // beat writes its sample into the store
    } pals_ctl_t;

endpackage

// File: hdl/pals_phase_stage.sv
// ============================================================================
// pals_phase_stage : phase accumulator and record index
// Advances the loop phase, picks the record address and clamps the loop
// length for each accepted beat; results land in the first stage register.
// ============================================================================
module pals_phase_stage
    import pals_pkg::*;
#(
    parameter int STORE_DEPTH = 65536,
    parameter int ADDR_W      = $clog2(STORE_DEPTH),
    parameter int N_W         = ADDR_W + 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_fire,
    input  logic                         adv,
    input  logic        [FC_W-1:0]       loop_frames,
    input  logic        [PHASE_W-1:0]    phase_step,
    input  logic                         record_enable,
    input  logic                         buffer_valid,
    input  logic signed [IO_W-1:0]       in_sample,
    output pals_ctl_t                    ctl1,
    output logic        [PHASE_W-1:0]    phase1,
    output logic        [N_W-1:0]        len1,
    output logic        [ADDR_W-1:0]     waddr1,
    output logic signed [IO_W-1:0]       sample1
);

    pals_ctl_t                 ctl_reg;
    logic        [PHASE_W-1:0] phase_reg;
    logic        [PHASE_W-1:0] phase_next;
    logic        [FC_W-1:0]    rec_idx_reg;
    logic        [FC_W-1:0]    rec_idx_next;
    logic        [FC_W-1:0]    wr_idx;
    logic        [N_W-1:0]     len_next;
    logic        [N_W-1:0]     len_reg;
    logic        [ADDR_W-1:0]  waddr_reg;
    logic signed [IO_W-1:0]    sample_reg;
    logic                      do_rec;

    // loop length: zero means one, clamp to the store depth
    always_comb
    begin
        if (loop_frames == '0)
            len_next = N_W'(1);
        else if (32'(loop_frames) > 32'(STORE_DEPTH))
            len_next = N_W'(STORE_DEPTH);
        else
            len_next = N_W'(loop_frames);
    end

    // phase wraps modulo 2^32; record index restarts outside the loop
    always_comb
    begin
        phase_next   = phase_reg + phase_step;
        wr_idx       = (32'(rec_idx_reg) >= 32'(len_next)) ? '0 : rec_idx_reg;
        rec_idx_next = wr_idx + FC_W'(1);
        do_rec       = buffer_valid && record_enable;
    end

    // architectural state, frozen while the buffer is invalid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            rec_idx_reg <= '0;
        end
        else if (in_fire && buffer_valid)
        begin
            phase_reg <= phase_next;
            if (record_enable)
                rec_idx_reg <= rec_idx_next;
        end
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (adv)
        begin
            ctl_reg.vld    <= in_fire;
            ctl_reg.active <= in_fire && buffer_valid;
            ctl_reg.rec    <= in_fire && do_rec;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (adv && in_fire)
        begin
            len_reg    <= len_next;
            waddr_reg  <= ADDR_W'(wr_idx);
            sample_reg <= in_sample;
        end
    end

    assign ctl1    = ctl_reg;
    assign phase1  = phase_reg;
    assign len1    = len_reg;
    assign waddr1  = waddr_reg;
    assign sample1 = sample_reg;

endmodule

// File: hdl/pals_index_stage.sv
// ============================================================================
// pals_index_stage : play index multiplier
// Scales the phase by the loop length and keeps the integer part as the
// read address of the store.
// ============================================================================
module pals_index_stage
    import pals_pkg::*;
#(
    parameter int STORE_DEPTH = 65536,
    parameter int ADDR_W      = $clog2(STORE_DEPTH),
    parameter int N_W         = ADDR_W + 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  pals_ctl_t                    ctl1,
    input  logic        [PHASE_W-1:0]    phase1,
    input  logic        [N_W-1:0]        len1,
    input  logic        [ADDR_W-1:0]     waddr1,
    input  logic signed [IO_W-1:0]       sample1,
    output pals_ctl_t                    ctl2,
    output logic        [PHASE_W-1:0]    phase2,
    output logic        [ADDR_W-1:0]     raddr2,
    output logic        [ADDR_W-1:0]     waddr2,
    output logic signed [IO_W-1:0]       sample2
);

    localparam int PROD_W = PHASE_W + N_W;

    pals_ctl_t                 ctl_reg;
    logic        [PROD_W-1:0]  prod;
    logic        [PHASE_W-1:0] phase_reg;
    logic        [ADDR_W-1:0]  raddr_reg;
    logic        [ADDR_W-1:0]  waddr_reg;
    logic signed [IO_W-1:0]    sample_reg;

    // floor(phase * len); result is below len, so it fits the address
    assign prod = PROD_W'(phase1) * PROD_W'(len1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (adv)
            ctl_reg <= ctl1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            phase_reg  <= phase1;
            raddr_reg  <= prod[PHASE_W +: ADDR_W];
            waddr_reg  <= waddr1;
            sample_reg <= sample1;
        end
    end

    assign ctl2    = ctl_reg;
    assign phase2  = phase_reg;
    assign raddr2  = raddr_reg;
    assign waddr2  = waddr_reg;
    assign sample2 = sample_reg;

endmodule

// File: hdl/pals_store.sv
// ============================================================================
// pals_store : loop sample memory
// Dual-port store with read-before-write in the same cycle. Writes always
// fill the store from entry zero upward, so a fill count marks which
// entries hold recorded data; anything above it reads as zero.
// ============================================================================
module pals_store
    import pals_pkg::*;
#(
    parameter int STORE_DEPTH = 65536,
    parameter int SAMPLE_BITS = 24,
    parameter int ADDR_W      = $clog2(STORE_DEPTH),
    parameter int N_W         = ADDR_W + 1
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  pals_ctl_t                      ctl2,
    input  logic        [PHASE_W-1:0]      phase2,
    input  logic        [ADDR_W-1:0]       raddr2,
    input  logic        [ADDR_W-1:0]       waddr2,
    input  logic signed [IO_W-1:0]         sample2,
    output pals_ctl_t                      ctl3,
    output logic        [PHASE_W-1:0]      phase3,
    output logic                           hit3,
    output logic signed [SAMPLE_BITS-1:0]  rdata3
);

    logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];

    pals_ctl_t                     ctl_reg;
    logic        [PHASE_W-1:0]     phase_reg;
    logic                          hit_reg;
    logic        [N_W-1:0]         fill_reg;
    logic        [N_W-1:0]         fill_next;
    logic        [N_W-1:0]         wr_end;
    logic signed [SAMPLE_BITS-1:0] rdata_reg;
    logic signed [SAMPLE_BITS-1:0] wdata;
    logic                          rd_en;
    logic                          wr_en;

    assign rd_en  = adv && ctl2.vld && ctl2.active;
    assign wr_en  = adv && ctl2.vld && ctl2.rec;
    assign wdata  = SAMPLE_BITS'(sample2);
    assign wr_end = N_W'({1'b0, waddr2}) + N_W'(1);

    // fill count grows to cover the highest written entry
    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && (wr_end > fill_reg))
            fill_next = wr_end;
    end

    // memory: read sees the entry before this cycle's write
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= mem[raddr2];
        if (wr_en)
            mem[waddr2] <= wdata;
    end

    // control, fill count and hit flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            fill_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (adv)
            begin
                ctl_reg <= ctl2;
                hit_reg <= (N_W'({1'b0, raddr2}) < fill_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            phase_reg <= phase2;
    end

    assign ctl3   = ctl_reg;
    assign phase3 = phase_reg;
    assign hit3   = hit_reg;
    assign rdata3 = rdata_reg;

endmodule

// File: hdl/phase_accumulator_loop_sampler.sv
// ============================================================================
// phase_accumulator_loop_sampler : looping sampler with record
// Plays a stored loop at a signed phase rate while optionally recording
// the incoming stream into the same store.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall / in_sample) takes one audio sample
//   per beat. Output channel (out_valid / out_stall / out_sample /
//   sync_phase) returns exactly one beat per input beat, in order.
//   Configuration port (cfg_valid / cfg_ready / cfg_addr / cfg_data) is
//   always ready; write it only while no beats are in flight.
//   Depth: three register stages; out_valid comes straight from the third
//   stage's valid bit, with no combinational path from in_valid to out_valid.
//   Throughput: one beat per cycle while out_stall stays low, set by the
//   dual-port store (one read and one write a cycle) and a single 32 x N multiplier stage.
//   Pipeline: phase/record index -> index multiply -> store read/write.
//   Reset: phase and record index go to zero, registers take their default
//   values, and the store reads as zero through a fill count; no clearing
//   pass is needed, so beats are taken right after reset.
//   Stall: each stage holds while the one after it is full and stalled;
//   empty stages still fill, so in_stall rises only with the pipe full.
//   With buffer_valid low, beats return zero sample and zero phase.
// ============================================================================
module phase_accumulator_loop_sampler
    import pals_pkg::*;
#(
    parameter int STORE_DEPTH = 65536,
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [IO_W-1:0]      in_sample,
    // output stream
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [IO_W-1:0]      out_sample,
    output logic        [PHASE_W-1:0]   sync_phase,
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic        [CFG_ADDR_W-1:0] cfg_addr,
    input  logic        [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int N_W    = ADDR_W + 1;

    logic        [FC_W-1:0]        loop_frames_reg;
    logic        [PHASE_W-1:0]     phase_step_reg;
    logic                          record_enable_reg;
    logic                          buffer_valid_reg;

    pals_ctl_t                     ctl1;
    pals_ctl_t                     ctl2;
    pals_ctl_t                     ctl3;
    logic        [PHASE_W-1:0]     phase1;
    logic        [PHASE_W-1:0]     phase2;
    logic        [PHASE_W-1:0]     phase3;
    logic        [N_W-1:0]         len1;
    logic        [ADDR_W-1:0]      waddr1;
    logic        [ADDR_W-1:0]      waddr2;
    logic        [ADDR_W-1:0]      raddr2;
    logic signed [IO_W-1:0]        sample1;
    logic signed [IO_W-1:0]        sample2;
    logic                          hit3;
    logic signed [SAMPLE_BITS-1:0] rdata3;
    logic                          en1;
    logic                          en2;
    logic                          en3;
    logic                          in_fire;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_frames_reg   <= LOOP_FRAMES_RST;
            phase_step_reg    <= PHASE_STEP_RST;
            record_enable_reg <= RECORD_ENABLE_RST;
            buffer_valid_reg  <= BUFFER_VALID_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                CFG_LOOP_FRAMES:   loop_frames_reg   <= cfg_data[FC_W-1:0];
                CFG_PHASE_STEP:    phase_step_reg    <= cfg_data[PHASE_W-1:0];
                CFG_RECORD_ENABLE: record_enable_reg <= cfg_data[0];
                CFG_BUFFER_VALID:  buffer_valid_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // stage advance: a stage moves when empty or when the next one moves
    assign en3      = !ctl3.vld || !out_stall;
    assign en2      = !ctl2.vld || en3;
    assign en1      = !ctl1.vld || en2;
    assign in_stall = !en1;
    assign in_fire  = in_valid && en1;

    pals_phase_stage #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W),
        .N_W         (N_W)
    ) u_phase (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .adv           (en1),
        .loop_frames   (loop_frames_reg),
        .phase_step    (phase_step_reg),
        .record_enable (record_enable_reg),
        .buffer_valid  (buffer_valid_reg),
        .in_sample     (in_sample),
        .ctl1          (ctl1),
        .phase1        (phase1),
        .len1          (len1),
        .waddr1        (waddr1),
        .sample1       (sample1)
    );

    pals_index_stage #(
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W),
        .N_W         (N_W)
    ) u_index (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (en2),
        .ctl1    (ctl1),
        .phase1  (phase1),
        .len1    (len1),
        .waddr1  (waddr1),
        .sample1 (sample1),
        .ctl2    (ctl2),
        .phase2  (phase2),
        .raddr2  (raddr2),
        .waddr2  (waddr2),
        .sample2 (sample2)
    );

    pals_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_W      (ADDR_W),
        .N_W         (N_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (en3),
        .ctl2    (ctl2),
        .phase2  (phase2),
        .raddr2  (raddr2),
        .waddr2  (waddr2),
        .sample2 (sample2),
        .ctl3    (ctl3),
        .phase3  (phase3),
        .hit3    (hit3),
        .rdata3  (rdata3)
    );

    // output beat: zero when the buffer was invalid or the entry unwritten
    assign out_valid  = ctl3.vld;
    assign out_sample = (ctl3.active && hit3) ? IO_W'(rdata3) : '0;
    assign sync_phase = ctl3.active ? phase3 : '0;

endmodule
